// ===== hdl/bmpr_pkg.sv =====
// Shared types and constants for the bitmap pixel stream reader.
package bmpr_pkg;

    // Header layout: last byte of each captured little-endian word
    localparam int HEADER_LEN     = 34;
    localparam int POS_OFFSET_END = 13;
    localparam int POS_WIDTH_END  = 21;
    localparam int POS_HEIGHT_END = 25;

    localparam int POS_W  = 6;
    localparam int WORD_W = 32;
    localparam int COL_W  = 12;
    localparam int ROW_W  = 12;

    localparam int MAX_DIM_DEFAULT = 4096;

    // One raw file byte
    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_file;
    } in_item_t;

    // One emitted pixel
    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last_pixel;
    } out_item_t;

endpackage

// ===== hdl/bmpr_in_stage.sv =====
// Input register slice that holds one byte item for the parser.
module bmpr_in_stage
    import bmpr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     in_valid,
    output in_item_t in_item
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;

    // Refill the slot whenever it is empty or being drained this cycle
    assign s_ready       = !in_valid_reg || take;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_item  = in_item_reg;

endmodule

// ===== hdl/bmpr_core.sv =====
// Parse state, header capture, pixel assembly and the result register.
module bmpr_core
    import bmpr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  in_item_t  in_item,
    output logic      take,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // Keep at least two width bits so the row padding can be read off them
    localparam int DIM_W = ($clog2(MAX_DIM + 1) > 2) ? $clog2(MAX_DIM + 1) : 2;
    localparam int CMP_W = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } phase_t;

    phase_t             phase_reg,  phase_next,  eff_phase;
    logic [POS_W-1:0]   pos_reg,    pos_next,    eff_pos;
    logic [WORD_W-1:0]  word_reg,   word_next,   eff_word;
    logic [WORD_W-1:0]  offset_reg, offset_next, eff_offset;
    logic [DIM_W-1:0]   width_reg,  width_next,  eff_width;
    logic [DIM_W-1:0]   height_reg, height_next, eff_height;
    logic [WORD_W-1:0]  skip_reg,   skip_next,   eff_skip;
    logic [1:0]         bip_reg,    bip_next,    eff_bip;
    logic [15:0]        held_reg,   held_next,   eff_held;
    logic [COL_W-1:0]   col_reg,    col_next,    eff_col;
    logic [ROW_W-1:0]   row_reg,    row_next,    eff_row;
    logic [1:0]         pad_reg,    pad_next,    eff_pad;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg,    res;

    logic               sof;
    logic [7:0]         b;
    logic               emit;
    logic               enter_pixels;
    logic               last_col;
    logic               last_row;
    logic [DIM_W-1:0]   word_sat;
    logic [WORD_W-1:0]  skip_dec;
    logic [1:0]         pad_dec;

    assign sof = in_item.start_of_file;
    assign b   = in_item.byte_value;

    // Consume the held byte when the result slot can take a pixel
    assign take = in_valid && (!out_valid_reg || m_ready);

    // Restart from a cleared parse when the byte opens a new file
    always_comb begin
        eff_phase  = sof ? PH_HEADER : phase_reg;
        eff_pos    = sof ? '0 : pos_reg;
        eff_word   = sof ? '0 : word_reg;
        eff_offset = sof ? '0 : offset_reg;
        eff_width  = sof ? '0 : width_reg;
        eff_height = sof ? '0 : height_reg;
        eff_skip   = sof ? '0 : skip_reg;
        eff_bip    = sof ? '0 : bip_reg;
        eff_held   = sof ? '0 : held_reg;
        eff_col    = sof ? '0 : col_reg;
        eff_row    = sof ? '0 : row_reg;
        eff_pad    = sof ? '0 : pad_reg;
    end

    // Shift in the header byte and saturate a dimension word
    assign word_next = {b, eff_word[WORD_W-1:8]};
    assign word_sat  = (word_next > WORD_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                      : word_next[DIM_W-1:0];
    assign skip_dec  = (eff_skip != '0) ? eff_skip - WORD_W'(1) : eff_skip;
    assign pad_dec   = (eff_pad != '0) ? eff_pad - 2'd1 : eff_pad;

    assign last_col = (CMP_W'(eff_col) + CMP_W'(1)) >= CMP_W'(eff_width);
    assign last_row = (CMP_W'(eff_row) + CMP_W'(1)) >= CMP_W'(eff_height);

    // Per-byte parse step
    always_comb begin
        phase_next   = eff_phase;
        pos_next     = eff_pos;
        offset_next  = eff_offset;
        width_next   = eff_width;
        height_next  = eff_height;
        skip_next    = eff_skip;
        bip_next     = eff_bip;
        held_next    = eff_held;
        col_next     = eff_col;
        row_next     = eff_row;
        pad_next     = eff_pad;
        emit         = 1'b0;
        enter_pixels = 1'b0;

        res.red        = b;
        res.green      = eff_held[15:8];
        res.blue       = eff_held[7:0];
        res.column     = eff_col;
        res.row        = eff_row;
        res.last_pixel = last_col && last_row;

        unique case (eff_phase)
            PH_HEADER: begin
                if (eff_pos == POS_W'(POS_OFFSET_END)) begin
                    offset_next = word_next;
                end
                if (eff_pos == POS_W'(POS_WIDTH_END)) begin
                    width_next = word_sat;
                end
                if (eff_pos == POS_W'(POS_HEIGHT_END)) begin
                    height_next = word_sat;
                end
                if (eff_pos >= POS_W'(HEADER_LEN - 1)) begin
                    pos_next = '0;
                    if (eff_offset > WORD_W'(HEADER_LEN)) begin
                        skip_next  = eff_offset - WORD_W'(HEADER_LEN);
                        phase_next = PH_SKIP;
                    end else begin
                        skip_next    = '0;
                        enter_pixels = 1'b1;
                    end
                end else begin
                    pos_next = eff_pos + POS_W'(1);
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    enter_pixels = 1'b1;
                end
            end
            PH_PAD: begin
                pad_next = pad_dec;
                if (pad_dec == '0) begin
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                unique case (eff_bip)
                    2'd0: begin
                        held_next = {8'h00, b};
                        bip_next  = 2'd1;
                    end
                    2'd1: begin
                        held_next = {b, eff_held[7:0]};
                        bip_next  = 2'd2;
                    end
                    default: begin
                        emit      = 1'b1;
                        bip_next  = 2'd0;
                        held_next = '0;
                        if (!last_col) begin
                            col_next = eff_col + COL_W'(1);
                        end else if (last_row) begin
                            phase_next = PH_DONE;
                        end else begin
                            col_next = '0;
                            row_next = eff_row + ROW_W'(1);
                            // (4 - 3w mod 4) mod 4 reduces to w mod 4
                            pad_next = eff_width[1:0];
                            if (eff_width[1:0] != 2'd0) begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                endcase
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Start the pixel area, or finish at once on an empty image
        if (enter_pixels) begin
            bip_next  = '0;
            held_next = '0;
            col_next  = '0;
            row_next  = '0;
            pad_next  = '0;
            if (width_next == '0 || height_next == '0) begin
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_PIXEL;
            end
        end
    end

    // Load a new pixel, or drop the current one once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            word_reg      <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            skip_reg      <= '0;
            bip_reg       <= '0;
            held_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                offset_reg <= offset_next;
                width_reg  <= width_next;
                height_reg <= height_next;
                skip_reg   <= skip_next;
                bip_reg    <= bip_next;
                held_reg   <= held_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                pad_reg    <= pad_next;
                if (eff_phase == PH_HEADER) begin
                    word_reg <= word_next;
                end else begin
                    word_reg <= eff_word;
                end
            end
        end
        if (take && emit) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled pixel changed");

    a_column_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXEL |-> CMP_W'(col_reg) < CMP_W'(width_reg))
        else $error("column past image width");

    a_pad_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> pad_reg != 2'd0)
        else $error("pad phase with nothing to skip");

    a_skip_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_reg != '0)
        else $error("skip phase with nothing to skip");

    a_byte_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        bip_reg != 2'd3)
        else $error("pixel byte slot out of range");

endmodule

// ===== hdl/bmp_pixel_stream_reader.sv =====
// Top level: 24-bit bitmap byte stream in, pixels with coordinates out.
//
// Usage:
//   s_valid/s_ready/s_item carry one file byte per item; start_of_file on a
//   byte restarts parsing with that byte as file byte zero. After the 34-byte
//   header and the skip to the pixel offset, every third byte completes a
//   pixel that leaves on m_valid/m_ready/m_item (blue, green, red order in
//   the file), with column, row and a last_pixel mark. Row padding, header
//   and trailing bytes produce no item.
//   Throughput: one byte per cycle, sustained while the receiver keeps up;
//   the parse step is a single pass of counter logic between the input
//   register and the result register.
//   Path: a pixel's third byte is accepted into the input register, then
//   the parse step loads the pixel into the result register, which raises
//   m_valid; a receiver stall can hold the byte in the input register.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the header phase at file byte zero.
//   When the receiver stalls, the pending pixel holds on m_item; one more
//   byte is still taken if the input register is empty, then s_ready falls.
module bmp_pixel_stream_reader
    import bmpr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic     in_valid;
    logic     take;
    in_item_t in_item;

    bmpr_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    bmpr_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .in_item  (in_item),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
